// ===== hw/rtl/msscan_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package msscan_pkg;

  localparam int SLOT_W      = 3;
  localparam int FLAG_W      = 8;
  localparam int LEVEL_W     = 10;
  localparam int DIFF_W      = 11;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;
  localparam int MAX_EVENTS  = 3;
  localparam int EVCNT_W     = 2;

  localparam logic [LEVEL_W-1:0] BEACON_PREV_RESET = 10'd1023;

  localparam logic [CFG_ADDR_W-1:0] REG_BEACON_HIGH = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BEACON_LOW  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TAPE_HIGH   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TAPE_LOW    = 2'd3;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_BUMP         = 3'd1,
    EV_BEACON_LOST  = 3'd2,
    EV_BEACON_FOUND = 3'd3,
    EV_TRACK_FOUND  = 3'd4,
    EV_TRACK_LOST   = 3'd5,
    EV_TAPE         = 3'd6
  } event_kind_e;

  typedef enum logic {
    OP_PASS = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef struct packed {
    op_e                op;
    logic               bump_pin;
    logic [LEVEL_W-1:0] beacon_sample;
    logic [LEVEL_W-1:0] tape_sample;
    logic               track_pin;
  } item_t;

  typedef struct packed {
    event_kind_e       kind;
    logic [FLAG_W-1:0] mask;
    logic [FLAG_W-1:0] level;
  } evt_t;

  localparam evt_t EVT_NONE = '{kind: EV_NONE, mask: '0, level: '0};

endpackage

`default_nettype wire

// ===== hw/rtl/msscan_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msscan_front
  import msscan_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,  // bump_pin, beacon_sample, tape_sample, track_pin
  input  wire logic        s_axis_tuser_i,  // is_poll_tick
  input  wire logic        q_ready_i,
  output logic             q_push_o,
  output item_t            q_item_o
);

  logic settle_q;
  logic settle_d;

  assign s_axis_tready_o = q_ready_i;
  assign q_push_o        = s_axis_tvalid_i && q_ready_i;

  always_comb begin
    q_item_o.op            = (s_axis_tuser_i && !settle_q) ? OP_READ : OP_PASS;
    q_item_o.bump_pin      = s_axis_tdata_i[0];
    q_item_o.beacon_sample = s_axis_tdata_i[10:1];
    q_item_o.tape_sample   = s_axis_tdata_i[20:11];
    q_item_o.track_pin     = s_axis_tdata_i[21];
  end

  // read and settle ticks alternate
  assign settle_d = (q_push_o && s_axis_tuser_i) ? !settle_q : settle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 1'b0;
    end else begin
      settle_q <= settle_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/msscan_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msscan_queue
  import msscan_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       ready_o,
  output logic       valid_o,
  output item_t      item_o,
  input  wire logic  pop_i
);

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push;
  logic              do_pop;

  assign ready_o = cnt_q != QCNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/msscan_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msscan_back
  import msscan_pkg::*;
#(
  parameter int MUX_SLOTS    = 8,
  parameter int BUMP_COUNT   = 4,
  parameter int BEACON_COUNT = 4,
  parameter int TAPE_COUNT   = 5
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  q_valid_i,
  input  wire item_t                 q_item_i,
  output logic                       q_pop_o,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [23:0]                m_axis_tdata_o,  // event_mask, event_level, mux_select, leds_on
  output logic [2:0]                 m_axis_tuser_o,  // event_kind
  output logic                       m_axis_tlast_o
);

  localparam int BIW = (BEACON_COUNT > 1) ? $clog2(BEACON_COUNT) : 1;
  localparam int TIW = (TAPE_COUNT > 1) ? $clog2(TAPE_COUNT) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]              state_q;
  logic [LEVEL_W-1:0]      beacon_high_q;
  logic [LEVEL_W-1:0]      beacon_low_q;
  logic signed [DIFF_W-1:0] tape_high_q;
  logic signed [DIFF_W-1:0] tape_low_q;

  logic [SLOT_W-1:0]       slot_count_q;
  logic                    led_phase_q;
  logic [FLAG_W-1:0]       bump_pressed_q;
  logic [LEVEL_W-1:0]      beacon_prev_q [BEACON_COUNT];
  logic                    track_votes_q [MAX_EVENTS];
  logic                    track_present_q;
  logic [LEVEL_W-1:0]      tape_dark_q [TAPE_COUNT];
  logic [LEVEL_W-1:0]      tape_lit_q [TAPE_COUNT];
  logic signed [DIFF_W-1:0] tape_prev_q [TAPE_COUNT];

  evt_t                    evt_q [MAX_EVENTS];
  logic [EVCNT_W-1:0]      n_q;
  logic [EVCNT_W-1:0]      idx_q;
  logic [TIW-1:0]          walk_q;
  logic [FLAG_W-1:0]       chg_q;
  logic [FLAG_W-1:0]       on_q;

  logic                    take;
  logic                    read_tick;
  logic [SLOT_W-1:0]       s;
  logic [FLAG_W-1:0]       bit_sel;
  logic                    bump_ok;
  logic                    beacon_ok;
  logic                    tape_ok;
  logic                    bump_fire;
  logic [LEVEL_W-1:0]      beacon_old;
  logic                    bcn_gone;
  logic                    bcn_seen;
  logic                    vote_slot;
  logic [1:0]              vote_idx;
  logic                    track_now;
  logic                    track_fire;
  logic                    wrap;
  logic                    start_walk;
  logic [SLOT_W-1:0]       slot_d;
  evt_t                    list_d [MAX_EVENTS];
  logic [EVCNT_W-1:0]      cnt_d;

  logic [LEVEL_W-1:0]      lit_rd;
  logic [LEVEL_W-1:0]      dark_rd;
  logic signed [DIFF_W-1:0] prev_rd;
  logic signed [DIFF_W-1:0] diff;
  logic                    tape_up;
  logic                    tape_down;
  logic [FLAG_W-1:0]       walk_bit;
  logic [FLAG_W-1:0]       chg_d;
  logic [FLAG_W-1:0]       on_d;
  logic                    walk_last;

  evt_t                    cur;

  assign take      = (state_q == ST_IDLE) && q_valid_i;
  assign q_pop_o   = take;
  assign read_tick = take && (q_item_i.op == OP_READ);

  assign s       = slot_count_q;
  assign bit_sel = FLAG_W'(1) << s;

  assign bump_ok   = {1'b0, s} < 4'(BUMP_COUNT);
  assign beacon_ok = {1'b0, s} < 4'(BEACON_COUNT);
  assign tape_ok   = {1'b0, s} < 4'(TAPE_COUNT);

  assign bump_fire  = bump_ok && ((!q_item_i.bump_pin) != bump_pressed_q[s]);
  assign beacon_old = beacon_prev_q[s[BIW-1:0]];
  assign bcn_gone   = beacon_ok && (q_item_i.beacon_sample > beacon_high_q)
                      && (beacon_old < beacon_high_q);
  assign bcn_seen   = beacon_ok && !bcn_gone
                      && (q_item_i.beacon_sample < beacon_low_q)
                      && (beacon_old > beacon_low_q);

  // votes at slots 0, 3 and 6, best of three at slot 6
  assign vote_slot  = (s == 3'd0) || (s == 3'd3) || (s == 3'd6);
  assign vote_idx   = (s == 3'd6) ? 2'd2 : ((s == 3'd3) ? 2'd1 : 2'd0);
  assign track_now  = (2'(track_votes_q[0]) + 2'(track_votes_q[1])
                       + 2'(q_item_i.track_pin)) >= 2'd2;
  assign track_fire = (s == 3'd6) && (track_now != track_present_q);

  assign wrap       = s == SLOT_W'(MUX_SLOTS - 1);
  assign start_walk = wrap && led_phase_q;
  assign slot_d     = wrap ? '0 : s + 1'b1;

  always_comb begin
    for (int i = 0; i < MAX_EVENTS; i++) begin
      list_d[i] = EVT_NONE;
    end
    cnt_d = '0;
    if (bump_fire) begin
      list_d[cnt_d] = '{kind: EV_BUMP, mask: bit_sel, level: bump_pressed_q ^ bit_sel};
      cnt_d = cnt_d + 1'b1;
    end
    if (bcn_gone) begin
      list_d[cnt_d] = '{kind: EV_BEACON_LOST, mask: bit_sel, level: '0};
      cnt_d = cnt_d + 1'b1;
    end else if (bcn_seen) begin
      list_d[cnt_d] = '{kind: EV_BEACON_FOUND, mask: bit_sel, level: '0};
      cnt_d = cnt_d + 1'b1;
    end
    if (track_fire) begin
      list_d[cnt_d] = '{kind: track_now ? EV_TRACK_FOUND : EV_TRACK_LOST,
                        mask: '0, level: '0};
      cnt_d = cnt_d + 1'b1;
    end
  end

  // tape hysteresis, one sensor a cycle
  assign lit_rd    = tape_lit_q[walk_q];
  assign dark_rd   = tape_dark_q[walk_q];
  assign prev_rd   = tape_prev_q[walk_q];
  assign diff      = $signed({1'b0, lit_rd}) - $signed({1'b0, dark_rd});
  assign tape_up   = (diff > tape_high_q) && (prev_rd < tape_high_q);
  assign tape_down = !tape_up && (diff < tape_low_q) && (prev_rd > tape_low_q);
  assign walk_bit  = FLAG_W'(1) << walk_q;
  assign chg_d     = (tape_up || tape_down) ? (chg_q | walk_bit) : chg_q;
  assign on_d      = tape_down ? (on_q | walk_bit) : on_q;
  assign walk_last = walk_q == TIW'(TAPE_COUNT - 1);

  assign cur             = evt_q[idx_q];
  assign m_axis_tvalid_o = state_q == ST_EMIT;
  assign m_axis_tuser_o  = cur.kind;
  assign m_axis_tdata_o  = {4'b0, led_phase_q, slot_count_q, cur.level, cur.mask};
  assign m_axis_tlast_o  = idx_q == (n_q - 1'b1);

  always_ff @(posedge clk_i) begin
    if (read_tick) begin
      if (tape_ok) begin
        if (led_phase_q) begin
          tape_lit_q[s[TIW-1:0]] <= q_item_i.tape_sample;
        end else begin
          tape_dark_q[s[TIW-1:0]] <= q_item_i.tape_sample;
        end
      end
      if (vote_slot) begin
        track_votes_q[vote_idx] <= q_item_i.track_pin;
      end
    end
    if (take) begin
      if (read_tick) begin
        evt_q <= list_d;
      end else begin
        evt_q[0] <= EVT_NONE;
      end
    end else if (state_q == ST_WALK && walk_last) begin
      if (chg_d != '0) begin
        evt_q[n_q] <= '{kind: EV_TAPE, mask: chg_d, level: on_d};
      end else if (n_q == '0) begin
        evt_q[0] <= EVT_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      beacon_high_q   <= 10'd700;
      beacon_low_q    <= 10'd300;
      tape_high_q     <= 11'sd200;
      tape_low_q      <= 11'sd100;
      slot_count_q    <= '0;
      led_phase_q     <= 1'b0;
      bump_pressed_q  <= '0;
      track_present_q <= 1'b0;
      n_q             <= '0;
      idx_q           <= '0;
      walk_q          <= '0;
      chg_q           <= '0;
      on_q            <= '0;
      for (int i = 0; i < BEACON_COUNT; i++) begin
        beacon_prev_q[i] <= BEACON_PREV_RESET;
      end
      for (int i = 0; i < TAPE_COUNT; i++) begin
        tape_prev_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_BEACON_HIGH: beacon_high_q <= cfg_wdata_i[LEVEL_W-1:0];
          REG_BEACON_LOW:  beacon_low_q  <= cfg_wdata_i[LEVEL_W-1:0];
          REG_TAPE_HIGH:   tape_high_q   <= $signed(cfg_wdata_i);
          REG_TAPE_LOW:    tape_low_q    <= $signed(cfg_wdata_i);
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (take) begin
            idx_q <= '0;
            if (read_tick) begin
              if (bump_fire) begin
                bump_pressed_q <= bump_pressed_q ^ bit_sel;
              end
              if (beacon_ok) begin
                beacon_prev_q[s[BIW-1:0]] <= q_item_i.beacon_sample;
              end
              if (s == 3'd6) begin
                track_present_q <= track_now;
              end
              slot_count_q <= slot_d;
              if (wrap) begin
                led_phase_q <= !led_phase_q;
              end
              if (start_walk) begin
                n_q     <= cnt_d;
                walk_q  <= '0;
                chg_q   <= '0;
                on_q    <= '0;
                state_q <= ST_WALK;
              end else begin
                n_q     <= (cnt_d == '0) ? EVCNT_W'(1) : cnt_d;
                state_q <= ST_EMIT;
              end
            end else begin
              n_q     <= EVCNT_W'(1);
              state_q <= ST_EMIT;
            end
          end
        end
        ST_WALK: begin
          tape_prev_q[walk_q] <= diff;
          chg_q               <= chg_d;
          on_q                <= on_d;
          if (walk_last) begin
            if (chg_d != '0) begin
              n_q <= n_q + 1'b1;
            end else if (n_q == '0) begin
              n_q <= EVCNT_W'(1);
            end
            state_q <= ST_EMIT;
          end else begin
            walk_q <= walk_q + 1'b1;
          end
        end
        ST_EMIT: begin
          if (m_axis_tready_i) begin
            if (m_axis_tlast_o) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> (n_q != '0) && (idx_q < n_q))
    else $error("result index outside the pending list");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o |=> state_q == ST_IDLE)
    else $error("back end did not return to idle after the final transfer");

  a_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> state_q != ST_IDLE)
    else $error("item taken from the queue without work following");

  a_walk_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> !led_phase_q && (slot_count_q == '0))
    else $error("tape pass outside the end of a lit sweep");

endmodule

`default_nettype wire

// ===== hw/rtl/multiplexed_sensor_scanner.sv =====
// the first result passes through the queue and the back end's idle state before emit; when a lit
//   sweep ends, a walk state comes first, and the tape sensors are walked one per cycle
// the back end takes no new item until the output has accepted every result of the last one
// a two-entry queue keeps taking input while results wait on the output, until it is full
// reset: asynchronous active low, clears slot and leds, resets hysteresis history, loads default thresholds
`timescale 1ns / 1ps
`default_nettype none

module multiplexed_sensor_scanner
  import msscan_pkg::*;
#(
  parameter int MUX_SLOTS    = 8,
  parameter int BUMP_COUNT   = 4,
  parameter int BEACON_COUNT = 4,
  parameter int TAPE_COUNT   = 5
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [23:0]           s_axis_tdata_i,  // bump_pin, beacon_sample, tape_sample, track_pin
  input  wire logic                  s_axis_tuser_i,  // is_poll_tick
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [23:0]                m_axis_tdata_o,  // event_mask, event_level, mux_select, leds_on
  output logic [2:0]                 m_axis_tuser_o,  // event_kind
  output logic                       m_axis_tlast_o
);

  logic  q_ready;
  logic  q_push;
  item_t q_item_in;
  logic  q_valid;
  item_t q_item_out;
  logic  q_pop;

  msscan_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_ready_i       (q_ready),
    .q_push_o        (q_push),
    .q_item_o        (q_item_in)
  );

  msscan_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_item_in),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (q_item_out),
    .pop_i   (q_pop)
  );

  msscan_back #(
    .MUX_SLOTS    (MUX_SLOTS),
    .BUMP_COUNT   (BUMP_COUNT),
    .BEACON_COUNT (BEACON_COUNT),
    .TAPE_COUNT   (TAPE_COUNT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item_out),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

// ===== tb/sensor_event_checker.sv =====
`timescale 1ns / 1ps

module sensor_event_checker
  import msscan_pkg::*;
#(
  parameter int MUX_SLOTS    = 8,
  parameter int BUMP_COUNT   = 4,
  parameter int BEACON_COUNT = 4,
  parameter int TAPE_COUNT   = 5
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  s_axis_tvalid_i,
  input  wire logic                  s_axis_tready_i,
  input  wire logic [23:0]           s_axis_tdata_i,  // bump_pin, beacon_sample, tape_sample, track_pin
  input  wire logic                  s_axis_tuser_i,  // is_poll_tick
  input  wire logic                  m_axis_tvalid_i,
  input  wire logic                  m_axis_tready_i,
  input  wire logic [23:0]           m_axis_tdata_i,  // event_mask, event_level, mux_select, leds_on
  input  wire logic [2:0]            m_axis_tuser_i,  // event_kind
  input  wire logic                  m_axis_tlast_i,
  output int                         mismatches_o,
  output int                         pending_o,
  output int                         results_o,
  output int                         events_o
);

  typedef struct {
    logic [2:0]        kind;
    logic [FLAG_W-1:0] mask;
    logic [FLAG_W-1:0] level;
    logic [SLOT_W-1:0] slot;
    logic              leds;
    logic              last;
  } scan_result_t;

  // thresholds as last written
  logic [LEVEL_W-1:0] beacon_high;
  logic [LEVEL_W-1:0] beacon_low;
  int                 tape_high;
  int                 tape_low;

  // scanner state
  logic               settle_due;
  logic [SLOT_W-1:0]  slot;
  logic [FLAG_W-1:0]  pressed;
  logic [LEVEL_W-1:0] beacon_last [4];
  logic [2:0]         votes;
  logic               wire_present;
  logic               lit_phase;
  logic [LEVEL_W-1:0] dark_level [8];
  logic [LEVEL_W-1:0] lit_level [8];
  int                 tape_last [8];

  scan_result_t       due_results [$];
  scan_result_t       want;
  scan_result_t       got;
  item_t              taken;

  task automatic scan_poll(input item_t it);
    evt_t              evs [$];
    logic [SLOT_W-1:0] s;
    logic [FLAG_W-1:0] slot_bit;
    logic              now;
    int                d;
    int                i;
    logic [FLAG_W-1:0] chg;
    logic [FLAG_W-1:0] on_tape;
    scan_result_t      r;
    if (it.op == OP_READ) begin
      if (settle_due) begin
        settle_due = 1'b0;
      end else begin
        s = slot;
        slot_bit = 8'd1 << s;
        if (s < BUMP_COUNT && (!it.bump_pin) != pressed[s]) begin
          pressed[s] = !pressed[s];
          evs.push_back(evt_t'{EV_BUMP, slot_bit, pressed});
        end
        if (s < BEACON_COUNT && s < 4) begin
          if (it.beacon_sample > beacon_high && beacon_last[s] < beacon_high)
            evs.push_back(evt_t'{EV_BEACON_LOST, slot_bit, 8'd0});
          else if (it.beacon_sample < beacon_low && beacon_last[s] > beacon_low)
            evs.push_back(evt_t'{EV_BEACON_FOUND, slot_bit, 8'd0});
          beacon_last[s] = it.beacon_sample;
        end
        if (s < TAPE_COUNT) begin
          if (lit_phase) lit_level[s] = it.tape_sample;
          else dark_level[s] = it.tape_sample;
        end
        if (s % 3 == 0) begin
          votes[s / 3] = it.track_pin;
          if (s == 6) begin
            now = ($countones(votes) >= 2);
            if (now != wire_present) begin
              evs.push_back(evt_t'{now ? EV_TRACK_FOUND : EV_TRACK_LOST, 8'd0, 8'd0});
              wire_present = now;
            end
          end
        end
        slot = SLOT_W'((int'(s) + 1) % MUX_SLOTS);
        if (slot == 0) begin
          if (!lit_phase) begin
            lit_phase = 1'b1;
          end else begin
            lit_phase = 1'b0;
            chg = '0;
            on_tape = '0;
            for (i = 0; i < TAPE_COUNT && i < 8; i++) begin
              d = int'(lit_level[i]) - int'(dark_level[i]);
              if (d > tape_high && tape_last[i] < tape_high) begin
                chg[i] = 1'b1;
              end else if (d < tape_low && tape_last[i] > tape_low) begin
                chg[i] = 1'b1;
                on_tape[i] = 1'b1;
              end
              tape_last[i] = d;
            end
            if (chg != 0) evs.push_back(evt_t'{EV_TAPE, chg, on_tape});
          end
        end
        settle_due = 1'b1;
      end
    end
    if (evs.size() == 0) evs.push_back(EVT_NONE);
    foreach (evs[k]) begin
      r.kind  = evs[k].kind;
      r.mask  = evs[k].mask;
      r.level = evs[k].level;
      r.slot  = slot;
      r.leds  = lit_phase;
      r.last  = (k == evs.size() - 1);
      due_results.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beacon_high  = 10'd700;
      beacon_low   = 10'd300;
      tape_high    = 200;
      tape_low     = 100;
      settle_due   = 1'b0;
      slot         = '0;
      pressed      = '0;
      votes        = '0;
      wire_present = 1'b0;
      lit_phase    = 1'b0;
      for (int i = 0; i < 4; i++) beacon_last[i] = BEACON_PREV_RESET;
      for (int i = 0; i < 8; i++) begin
        dark_level[i] = '0;
        lit_level[i]  = '0;
        tape_last[i]  = 0;
      end
      due_results.delete();
      mismatches_o = 0;
      results_o    = 0;
      events_o     = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.kind  = m_axis_tuser_i;
        got.mask  = m_axis_tdata_i[7:0];
        got.level = m_axis_tdata_i[15:8];
        got.slot  = m_axis_tdata_i[18:16];
        got.leds  = m_axis_tdata_i[19];
        got.last  = m_axis_tlast_i;
        results_o++;
        if (got.kind != EV_NONE) events_o++;
        if (due_results.size() == 0) begin
          mismatches_o++;
          $display("%0t: unexpected result, expected none, got kind %0d mask %h level %h",
                   $time, got.kind, got.mask, got.level);
        end else begin
          want = due_results.pop_front();
          if (got.kind !== want.kind || got.mask !== want.mask || got.level !== want.level ||
              got.slot !== want.slot || got.leds !== want.leds || got.last !== want.last) begin
            mismatches_o++;
            $display("%0t: mismatch, expected kind %0d mask %h level %h slot %0d leds %b last %b",
                     $time, want.kind, want.mask, want.level, want.slot, want.leds, want.last);
            $display("%0t:           got kind %0d mask %h level %h slot %0d leds %b last %b",
                     $time, got.kind, got.mask, got.level, got.slot, got.leds, got.last);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_BEACON_HIGH: beacon_high = cfg_wdata_i[LEVEL_W-1:0];
          REG_BEACON_LOW:  beacon_low  = cfg_wdata_i[LEVEL_W-1:0];
          REG_TAPE_HIGH:   tape_high   = $signed(cfg_wdata_i);
          REG_TAPE_LOW:    tape_low    = $signed(cfg_wdata_i);
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        taken.op            = op_e'(s_axis_tuser_i);
        taken.bump_pin      = s_axis_tdata_i[0];
        taken.beacon_sample = s_axis_tdata_i[10:1];
        taken.tape_sample   = s_axis_tdata_i[20:11];
        taken.track_pin     = s_axis_tdata_i[21];
        scan_poll(taken);
      end
    end
    pending_o = due_results.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import msscan_pkg::*;

  localparam int MUX_SLOTS    = 8;
  localparam int BUMP_COUNT   = 4;
  localparam int BEACON_COUNT = 4;
  localparam int TAPE_COUNT   = 5;
  localparam int CHUNKS       = 6;
  localparam int CHUNK_ITEMS  = 39;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = REG_BEACON_HIGH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [23:0]           s_tdata   = '0;
  logic                  s_tuser   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [23:0]           m_tdata;
  logic [2:0]            m_tuser;
  logic                  m_tlast;

  int tx_idle_pct = 31;
  int rx_idle_pct = 45;
  int cur_bh      = 700;
  int cur_bl      = 300;
  int items_sent  = 0;
  int mismatches;
  int pending;
  int results;
  int events;

  // directed read ticks: a dark sweep of all slots, then the start of a lit sweep
  logic [11:0]        dir_bump   = 12'hFE2;
  logic [11:0]        dir_track  = 12'h98D;
  logic [LEVEL_W-1:0] dir_beacon [12] = '{10'd1023, 10'd0, 10'd300, 10'd700, 10'd1023, 10'd0,
                                          10'd512, 10'd0, 10'd1023, 10'd701, 10'd299, 10'd701};
  logic [LEVEL_W-1:0] dir_tape   [12] = '{10'd0, 10'd1023, 10'd512, 10'd1023, 10'd1023, 10'd0,
                                          10'd0, 10'd1023, 10'd1023, 10'd0, 10'd1023, 10'd512};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multiplexed_sensor_scanner #(
    .MUX_SLOTS   (MUX_SLOTS),
    .BUMP_COUNT  (BUMP_COUNT),
    .BEACON_COUNT(BEACON_COUNT),
    .TAPE_COUNT  (TAPE_COUNT)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (cfg_addr),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast)
  );

  sensor_event_checker #(
    .MUX_SLOTS   (MUX_SLOTS),
    .BUMP_COUNT  (BUMP_COUNT),
    .BEACON_COUNT(BEACON_COUNT),
    .TAPE_COUNT  (TAPE_COUNT)
  ) checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (cfg_addr),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_i(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_i(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_i (m_tdata),
    .m_axis_tuser_i (m_tuser),
    .m_axis_tlast_i (m_tlast),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .results_o      (results),
    .events_o       (events)
  );

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  task automatic send_item(input item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, it.track_pin, it.tape_sample, it.beacon_sample, it.bump_pin};
    s_tuser  <= it.op;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic set_thresholds(input int bh, input int bl, input int th, input int tl);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_BEACON_HIGH;
    cfg_wdata <= {1'($urandom_range(0, 1)), 10'(bh)};
    @(posedge clk);
    cfg_addr  <= REG_BEACON_LOW;
    cfg_wdata <= {1'($urandom_range(0, 1)), 10'(bl)};
    @(posedge clk);
    cfg_addr  <= REG_TAPE_HIGH;
    cfg_wdata <= 11'(th);
    @(posedge clk);
    cfg_addr  <= REG_TAPE_LOW;
    cfg_wdata <= 11'(tl);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_bh = bh;
    cur_bl = bl;
  endtask

  function automatic item_t random_item();
    item_t it;
    it.op        = ($urandom_range(0, 9) == 0) ? OP_PASS : OP_READ;
    it.bump_pin  = 1'($urandom_range(0, 1));
    it.track_pin = 1'($urandom_range(0, 1));
    // bias beacon readings onto the rails and around the thresholds
    case ($urandom_range(0, 5))
      0:       it.beacon_sample = '0;
      1:       it.beacon_sample = '1;
      2:       it.beacon_sample = 10'(cur_bh + $urandom_range(0, 2) - 1);
      3:       it.beacon_sample = 10'(cur_bl + $urandom_range(0, 2) - 1);
      default: it.beacon_sample = 10'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       it.tape_sample = '0;
      1:       it.tape_sample = '1;
      default: it.tape_sample = 10'($urandom);
    endcase
    return it;
  endfunction

  initial begin
    int k;
    int chunk;
    int bh;
    int bl;
    int th;
    int tl;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(item_t'{OP_PASS, 1'b1, '1, '1, 1'b1});
    for (k = 0; k < 12; k++) begin
      if (k == 6) send_item(item_t'{OP_PASS, 1'b0, '0, '0, 1'b0});
      send_item(item_t'{OP_READ, dir_bump[k], dir_beacon[k], dir_tape[k], dir_track[k]});
      // settle tick, its data must be ignored
      send_item(item_t'{OP_READ, k[0], {LEVEL_W{k[0]}}, {LEVEL_W{k[0]}}, k[0]});
    end
    s_tvalid <= 1'b0;
    wait_drained();

    for (chunk = 0; chunk < CHUNKS; chunk++) begin
      case (chunk)
        0: set_thresholds(600, 400, 150, 50);
        1: set_thresholds(1023, 0, 1023, -1023);
        2: begin
          tx_idle_pct = 45;
          rx_idle_pct = 31;
          set_thresholds(0, 1023, -1023, 1023);
        end
        3: set_thresholds(0, 0, 0, 0);
        4: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          bh = $urandom_range(1, 1022);
          bl = $urandom_range(0, bh);
          th = int'($urandom_range(0, 2046)) - 1023;
          tl = th - int'($urandom_range(0, th + 1023));
          set_thresholds(bh, bl, th, tl);
        end
        default: set_thresholds(512, 511, -100, -300);
      endcase
      repeat (CHUNK_ITEMS) send_item(random_item());
      s_tvalid <= 1'b0;
      wait_drained();
    end

    repeat (16) @(posedge clk);
    @(negedge clk);
    $display("covered %0d input items over seven threshold settings", items_sent);
    $display("%0d results compared, %0d of them sensor events", results, events);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
